FILE: hw/rtl/calo_energy_calibration_macros.svh
// ----------------------------------------------------------------------------
// calo_energy_calibration_macros: assertion helpers
// shared property forms for the calibration checks
// ----------------------------------------------------------------------------
`ifndef CALO_ENERGY_CALIBRATION_MACROS_SVH
`define CALO_ENERGY_CALIBRATION_MACROS_SVH

// same-cycle implication, idle during reset
`define CEC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define CEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cec_pkg.sv
// ----------------------------------------------------------------------------
// cec_pkg: calorimeter energy calibration package
// widths, calibration curves, divider constants and the work item type
// ----------------------------------------------------------------------------
package cec_pkg;

    localparam int RAW_W            = 20;
    localparam int FACTOR_W         = 16;
    localparam int CORR_W           = 24;
    localparam int CODE_W           = 2;
    localparam int PID_W            = 3;
    localparam int ENERGY_FRAC_BITS = 4;
    localparam int FACTOR_FRAC_BITS = 12;

    localparam int EM_POINTS  = 12;
    localparam int HAD_POINTS = 9;
    localparam int MAX_POINTS = (EM_POINTS > HAD_POINTS) ? EM_POINTS : HAD_POINTS;
    localparam int SEG_W      = $clog2(MAX_POINTS);

    // breakpoints in whole MeV, factors in Q4.12
    localparam logic [15:0] EM_X_MEV [EM_POINTS] = '{
        16'd250, 16'd750, 16'd1250, 16'd1750, 16'd2250, 16'd2750,
        16'd3250, 16'd3750, 16'd4250, 16'd4750, 16'd5250, 16'd5750};
    localparam logic [FACTOR_W-1:0] EM_Y_Q12 [EM_POINTS] = '{
        16'd4813, 16'd4178, 16'd4055, 16'd4035, 16'd3994, 16'd3994,
        16'd3932, 16'd3850, 16'd3564, 16'd3277, 16'd2990, 16'd2724};
    localparam logic [15:0] HAD_X_MEV [HAD_POINTS] = '{
        16'd25, 16'd75, 16'd125, 16'd175, 16'd225, 16'd275, 16'd325, 16'd375, 16'd425};
    localparam logic [FACTOR_W-1:0] HAD_Y_Q12 [HAD_POINTS] = '{
        16'd34570, 16'd30228, 16'd31785, 16'd34959, 16'd38789,
        16'd42803, 16'd42885, 16'd39772, 16'd36332};

    // both curves have evenly spaced breakpoints: one segment width per curve
    localparam int EM_DX  = (int'(EM_X_MEV[1]) - int'(EM_X_MEV[0])) << ENERGY_FRAC_BITS;
    localparam int HAD_DX = (int'(HAD_X_MEV[1]) - int'(HAD_X_MEV[0])) << ENERGY_FRAC_BITS;
    localparam int MAX_DX = (EM_DX > HAD_DX) ? EM_DX : HAD_DX;
    localparam int MIN_DX = (EM_DX < HAD_DX) ? EM_DX : HAD_DX;

    // offset into segment reaches dx itself at the last breakpoint
    localparam int T_W   = $clog2(MAX_DX + 1);
    localparam int NUM_W = FACTOR_W + T_W + 1;

    // reciprocal scaled by 2^NUM_W: quotient estimate is low by at most one
    localparam longint unsigned EM_RECIP_FULL  = (64'd1 << NUM_W) / EM_DX;
    localparam longint unsigned HAD_RECIP_FULL = (64'd1 << NUM_W) / HAD_DX;
    localparam longint unsigned MAX_RECIP      = (64'd1 << NUM_W) / MIN_DX;
    localparam int RECIP_W = $clog2(MAX_RECIP + 1);

    localparam logic [RECIP_W-1:0] EM_RECIP  = RECIP_W'(EM_RECIP_FULL);
    localparam logic [RECIP_W-1:0] HAD_RECIP = RECIP_W'(HAD_RECIP_FULL);
    localparam logic [T_W-1:0]     EM_DXV    = T_W'(EM_DX);
    localparam logic [T_W-1:0]     HAD_DXV   = T_W'(HAD_DX);
    localparam logic [NUM_W-1:0]   EM_HALF   = NUM_W'(EM_DX / 2);
    localparam logic [NUM_W-1:0]   HAD_HALF  = NUM_W'(HAD_DX / 2);

    localparam logic MODE_EM  = 1'b0;
    localparam logic MODE_HAD = 1'b1;

    localparam logic [PID_W-1:0] PID_EM  = 3'd2;
    localparam logic [PID_W-1:0] PID_HAD = 3'd4;

    typedef enum logic [CODE_W-1:0] {
        RANGE_INTERP = 2'd0,
        RANGE_BELOW  = 2'd1,
        RANGE_ABOVE  = 2'd2
    } t_range;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // classified item: factor = y0 +/- round(d * t / dx)
    typedef struct packed {
        logic                mode;
        logic [RAW_W-1:0]    raw;
        t_range              code;
        logic [FACTOR_W-1:0] y0;
        logic [FACTOR_W-1:0] d;
        logic                neg;
        logic [T_W-1:0]      t;
    } t_work;

endpackage

FILE: hw/rtl/cec_front.sv
// ----------------------------------------------------------------------------
// cec_front: curve classification
// finds the range and segment of a raw energy and its interpolation terms
// ----------------------------------------------------------------------------
module cec_front (
    input  logic                         i_mode,
    input  logic [cec_pkg::RAW_W-1:0]    i_raw,
    output cec_pkg::t_work               o_work
);

    function automatic logic [cec_pkg::RAW_W-1:0] em_bp(input int idx);
        return cec_pkg::RAW_W'(32'(cec_pkg::EM_X_MEV[idx]) << cec_pkg::ENERGY_FRAC_BITS);
    endfunction

    function automatic logic [cec_pkg::RAW_W-1:0] had_bp(input int idx);
        return cec_pkg::RAW_W'(32'(cec_pkg::HAD_X_MEV[idx]) << cec_pkg::ENERGY_FRAC_BITS);
    endfunction

    cec_pkg::t_work em_work;
    cec_pkg::t_work had_work;

    // electromagnetic curve
    always_comb begin
        logic [cec_pkg::SEG_W-1:0]    seg;
        logic [cec_pkg::FACTOR_W-1:0] y0;
        logic [cec_pkg::FACTOR_W-1:0] y1;
        logic [cec_pkg::RAW_W-1:0]    x0;
        seg = '0;
        for (int i = 1; i <= cec_pkg::EM_POINTS - 2; i++) begin
            if (i_raw >= em_bp(i)) begin
                seg = cec_pkg::SEG_W'(i);
            end
        end
        x0 = em_bp(int'(seg));
        y0 = cec_pkg::EM_Y_Q12[seg];
        y1 = cec_pkg::EM_Y_Q12[int'(seg) + 1];
        em_work.mode = cec_pkg::MODE_EM;
        em_work.raw  = i_raw;
        if (i_raw < em_bp(0)) begin
            em_work.code = cec_pkg::RANGE_BELOW;
            em_work.y0   = cec_pkg::EM_Y_Q12[0];
            em_work.d    = '0;
            em_work.neg  = 1'b0;
            em_work.t    = '0;
        end else if (i_raw > em_bp(cec_pkg::EM_POINTS - 1)) begin
            em_work.code = cec_pkg::RANGE_ABOVE;
            em_work.y0   = cec_pkg::EM_Y_Q12[cec_pkg::EM_POINTS - 1];
            em_work.d    = '0;
            em_work.neg  = 1'b0;
            em_work.t    = '0;
        end else begin
            em_work.code = cec_pkg::RANGE_INTERP;
            em_work.y0   = y0;
            em_work.neg  = (y1 < y0);
            em_work.d    = (y1 < y0) ? (y0 - y1) : (y1 - y0);
            em_work.t    = cec_pkg::T_W'(i_raw - x0);
        end
    end

    // hadronic curve
    always_comb begin
        logic [cec_pkg::SEG_W-1:0]    seg;
        logic [cec_pkg::FACTOR_W-1:0] y0;
        logic [cec_pkg::FACTOR_W-1:0] y1;
        logic [cec_pkg::RAW_W-1:0]    x0;
        seg = '0;
        for (int i = 1; i <= cec_pkg::HAD_POINTS - 2; i++) begin
            if (i_raw >= had_bp(i)) begin
                seg = cec_pkg::SEG_W'(i);
            end
        end
        x0 = had_bp(int'(seg));
        y0 = cec_pkg::HAD_Y_Q12[seg];
        y1 = cec_pkg::HAD_Y_Q12[int'(seg) + 1];
        had_work.mode = cec_pkg::MODE_HAD;
        had_work.raw  = i_raw;
        if (i_raw < had_bp(0)) begin
            had_work.code = cec_pkg::RANGE_BELOW;
            had_work.y0   = cec_pkg::HAD_Y_Q12[0];
            had_work.d    = '0;
            had_work.neg  = 1'b0;
            had_work.t    = '0;
        end else if (i_raw > had_bp(cec_pkg::HAD_POINTS - 1)) begin
            had_work.code = cec_pkg::RANGE_ABOVE;
            had_work.y0   = cec_pkg::HAD_Y_Q12[cec_pkg::HAD_POINTS - 1];
            had_work.d    = '0;
            had_work.neg  = 1'b0;
            had_work.t    = '0;
        end else begin
            had_work.code = cec_pkg::RANGE_INTERP;
            had_work.y0   = y0;
            had_work.neg  = (y1 < y0);
            had_work.d    = (y1 < y0) ? (y0 - y1) : (y1 - y0);
            had_work.t    = cec_pkg::T_W'(i_raw - x0);
        end
    end

    assign o_work = (i_mode == cec_pkg::MODE_HAD) ? had_work : em_work;

endmodule

FILE: hw/rtl/cec_queue.sv
// ----------------------------------------------------------------------------
// cec_queue: work queue
// short first-in first-out buffer between classification and arithmetic
// ----------------------------------------------------------------------------
module cec_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cec_pkg::t_work i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cec_pkg::t_work o_pop_data
);

    cec_pkg::t_work                r_slot [cec_pkg::QUEUE_DEPTH];
    logic [cec_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [cec_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [cec_pkg::QPTR_W:0]      r_count;
    logic [cec_pkg::QPTR_W:0]      n_count;

    assign o_full     = (r_count == (cec_pkg::QPTR_W + 1)'(cec_pkg::QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_pop_data = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: hw/rtl/cec_back.sv
// ----------------------------------------------------------------------------
// cec_back: interpolation and correction pipeline
// six stages: product, reciprocal multiply, remainder, factor, energy, output
// ----------------------------------------------------------------------------
module cec_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_work_valid,
    input  cec_pkg::t_work                i_work,
    output logic                          o_work_take,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [cec_pkg::CORR_W-1:0]    o_energy,
    output logic [cec_pkg::FACTOR_W-1:0]  o_factor,
    output cec_pkg::t_range               o_code,
    output logic [cec_pkg::PID_W-1:0]     o_pid
);

    localparam int QDX_W  = cec_pkg::RECIP_W + cec_pkg::T_W;
    localparam int QM_W   = cec_pkg::NUM_W + cec_pkg::RECIP_W;
    localparam int PROD_W = cec_pkg::RAW_W + cec_pkg::FACTOR_W;
    localparam int SH_W   = PROD_W - cec_pkg::FACTOR_FRAC_BITS;

    typedef struct packed {
        logic                         mode;
        logic [cec_pkg::RAW_W-1:0]    raw;
        cec_pkg::t_range              code;
        logic [cec_pkg::FACTOR_W-1:0] y0;
        logic [cec_pkg::FACTOR_W-1:0] d;
        logic                         neg;
    } t_carry;

    logic [5:0]                      r_vld;
    logic                            move;

    t_carry                          r_c1, r_c2, r_c3, r_c4, r_c5;
    logic [cec_pkg::NUM_W-1:0]       r_num1, r_num2;
    logic [cec_pkg::RECIP_W-1:0]     r_q2, r_q3;
    logic [cec_pkg::NUM_W-1:0]       r_rem3;
    logic [cec_pkg::FACTOR_W-1:0]    r_fac4, r_fac5;
    logic [SH_W-1:0]                 r_sh5;

    logic [cec_pkg::NUM_W-1:0]       n_num1;
    logic [cec_pkg::RECIP_W-1:0]     n_q2;
    logic [cec_pkg::NUM_W-1:0]       n_rem3;
    logic [cec_pkg::FACTOR_W-1:0]    n_fac4;
    logic [SH_W-1:0]                 n_sh5;
    logic [cec_pkg::CORR_W-1:0]      n_energy;
    t_carry                          n_c1;

    // whole pipe advances unless the output register is held
    assign move        = !r_vld[5] || i_tready;
    assign o_work_take = move && i_work_valid;
    assign o_tvalid    = r_vld[5];

    // stage 1: d * t plus half a segment
    always_comb begin
        logic [cec_pkg::NUM_W-1:0] half;
        half = (i_work.mode == cec_pkg::MODE_HAD) ? cec_pkg::HAD_HALF : cec_pkg::EM_HALF;
        n_num1 = cec_pkg::NUM_W'(i_work.d) * cec_pkg::NUM_W'(i_work.t) + half;
        n_c1.mode = i_work.mode;
        n_c1.raw  = i_work.raw;
        n_c1.code = i_work.code;
        n_c1.y0   = i_work.y0;
        n_c1.d    = i_work.d;
        n_c1.neg  = i_work.neg;
    end

    // stage 2: quotient estimate through the reciprocal
    always_comb begin
        logic [cec_pkg::RECIP_W-1:0] recip;
        logic [QM_W-1:0]             qm;
        recip = (r_c1.mode == cec_pkg::MODE_HAD) ? cec_pkg::HAD_RECIP : cec_pkg::EM_RECIP;
        qm    = QM_W'(r_num1) * QM_W'(recip);
        n_q2  = qm[cec_pkg::NUM_W +: cec_pkg::RECIP_W];
    end

    // stage 3: remainder against the estimate
    always_comb begin
        logic [cec_pkg::T_W-1:0] dx;
        logic [QDX_W-1:0]        qdx;
        dx     = (r_c2.mode == cec_pkg::MODE_HAD) ? cec_pkg::HAD_DXV : cec_pkg::EM_DXV;
        qdx    = QDX_W'(r_q2) * QDX_W'(dx);
        n_rem3 = r_num2 - cec_pkg::NUM_W'(qdx);
    end

    // stage 4: fix the quotient, clamp to the span, apply to the left factor
    always_comb begin
        logic [cec_pkg::T_W-1:0]      dx;
        logic [cec_pkg::RECIP_W:0]    q_fix;
        logic [cec_pkg::FACTOR_W-1:0] step;
        dx    = (r_c3.mode == cec_pkg::MODE_HAD) ? cec_pkg::HAD_DXV : cec_pkg::EM_DXV;
        q_fix = (cec_pkg::RECIP_W + 1)'(r_q3);
        if (r_rem3 >= cec_pkg::NUM_W'(dx)) begin
            q_fix = q_fix + 1'b1;
        end
        if (q_fix > (cec_pkg::RECIP_W + 1)'(r_c3.d)) begin
            step = r_c3.d;
        end else begin
            step = cec_pkg::FACTOR_W'(q_fix);
        end
        n_fac4 = r_c3.neg ? (r_c3.y0 - step) : (r_c3.y0 + step);
    end

    // stage 5: raw energy times factor, rounded
    always_comb begin
        logic [PROD_W-1:0] prod;
        prod  = PROD_W'(r_c4.raw) * PROD_W'(r_fac4)
              + PROD_W'(1 << (cec_pkg::FACTOR_FRAC_BITS - 1));
        n_sh5 = prod[PROD_W-1:cec_pkg::FACTOR_FRAC_BITS];
    end

    // stage 6: saturate
    always_comb begin
        if ((SH_W + 1)'(r_sh5) > (SH_W + 1)'({cec_pkg::CORR_W{1'b1}})) begin
            n_energy = '1;
        end else begin
            n_energy = cec_pkg::CORR_W'(r_sh5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (move) begin
            r_vld <= {r_vld[4:0], i_work_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_c1     <= n_c1;
            r_num1   <= n_num1;
            r_c2     <= r_c1;
            r_num2   <= r_num1;
            r_q2     <= n_q2;
            r_c3     <= r_c2;
            r_q3     <= r_q2;
            r_rem3   <= n_rem3;
            r_c4     <= r_c3;
            r_fac4   <= n_fac4;
            r_c5     <= r_c4;
            r_fac5   <= r_fac4;
            r_sh5    <= n_sh5;
            o_energy <= n_energy;
            o_factor <= r_fac5;
            o_code   <= r_c5.code;
            o_pid    <= (r_c5.mode == cec_pkg::MODE_HAD) ? cec_pkg::PID_HAD : cec_pkg::PID_EM;
        end
    end

endmodule

FILE: hw/rtl/calo_energy_calibration.sv
// ----------------------------------------------------------------------------
// calo_energy_calibration: per-cluster calorimeter energy calibration
// path: each beat is queued, then passes the arithmetic pipe to the output register
// throughput: one beat per cycle while the output is not stalled, set by the six-stage arithmetic pipe
// reset: synchronous active low, empties the queue and clears all valids
// ----------------------------------------------------------------------------
module calo_energy_calibration (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] raw_energy, [23:20] zero
    input  logic        s_axis_tuser,   // [0] mode
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [23:0] corrected_energy, [39:24] correction_factor
    output logic [4:0]  m_axis_tuser    // [1:0] range_code, [4:2] pid_bits
);

    // front end: classify the beat against the selected curve
    cec_pkg::t_work front_work;
    cec_pkg::t_work queue_work;
    logic           queue_full;
    logic           queue_valid;
    logic           back_take;
    logic           push;

    logic [cec_pkg::CORR_W-1:0]   out_energy;
    logic [cec_pkg::FACTOR_W-1:0] out_factor;
    cec_pkg::t_range              out_code;
    logic [cec_pkg::PID_W-1:0]    out_pid;

    // beat accepted whenever the queue has a free slot
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    cec_front u_front (
        .i_mode (s_axis_tuser),
        .i_raw  (s_axis_tdata[cec_pkg::RAW_W-1:0]),
        .o_work (front_work)
    );

    // queue decouples classification from the arithmetic pipe
    cec_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (front_work),
        .o_full      (queue_full),
        .i_pop       (back_take),
        .o_valid     (queue_valid),
        .o_pop_data  (queue_work)
    );

    // back end: interpolation divide, factor, energy product, output register
    cec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (queue_valid),
        .i_work       (queue_work),
        .o_work_take  (back_take),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_energy     (out_energy),
        .o_factor     (out_factor),
        .o_code       (out_code),
        .o_pid        (out_pid)
    );

    // pack result fields, highest field listed first
    assign m_axis_tdata = {out_factor, out_energy};
    assign m_axis_tuser = {out_pid, out_code};

endmodule

FILE: hw/rtl/cec_checker.sv
// ----------------------------------------------------------------------------
// cec_checker: port-level checks
// output stability, legal codes and clamped end factors
// ----------------------------------------------------------------------------
`include "calo_energy_calibration_macros.svh"

module cec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser
);

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ s_axis_tuser;

    `CEC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")
    `CEC_ASSERT_SAME(a_pid_legal, m_axis_tvalid, (m_axis_tuser[4:2] == cec_pkg::PID_EM) || (m_axis_tuser[4:2] == cec_pkg::PID_HAD), "illegal pid bits")
    `CEC_ASSERT_SAME(a_code_legal, m_axis_tvalid, m_axis_tuser[1:0] != 2'd3, "illegal range code")
    `CEC_ASSERT_SAME(a_em_below, m_axis_tvalid && (m_axis_tuser[1:0] == cec_pkg::RANGE_BELOW) && (m_axis_tuser[4:2] == cec_pkg::PID_EM), m_axis_tdata[39:24] == cec_pkg::EM_Y_Q12[0], "em clamp below not first factor")
    `CEC_ASSERT_SAME(a_had_above, m_axis_tvalid && (m_axis_tuser[1:0] == cec_pkg::RANGE_ABOVE) && (m_axis_tuser[4:2] == cec_pkg::PID_HAD), m_axis_tdata[39:24] == cec_pkg::HAD_Y_Q12[cec_pkg::HAD_POINTS-1], "had clamp above not last factor")

endmodule

bind calo_energy_calibration cec_checker u_cec_checker (.*);
